>>> hw/rtl/gcq_pkg.sv
// ----------------------------------------------------------------------------
// gcq_pkg
// Shared widths, constants and types for the gain correct / quantize block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcq_pkg;

  localparam int PIX_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int NUM_W   = 32;
  localparam int DEN_W   = 16;
  localparam int Q_W     = 13;
  localparam int HI_W    = NUM_W - Q_W;
  localparam int CNT_W   = 25;
  localparam int SUM_W   = 32;
  localparam int THR_W   = 8;
  localparam int RES_W   = 4;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam int PIXELS_MAX_DEF = 16777216;

  localparam logic [RES_W-1:0] QMAX       = 4'd15;
  localparam logic [Q_W-1:0]   OVER_LIMIT = 13'd3968;
  localparam logic [Q_W-1:0]   CLAMP_BASE = 13'd3840;
  localparam logic [SUM_W:0]   DEV_SUM_MAX = 33'h0_8000_0000;
  localparam logic [THR_W-1:0] THR_RESET  = 8'd3;

  localparam logic REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic           sat;
    logic [Q_W-1:0] q;
  } div_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/gcq_in_if.sv
// ----------------------------------------------------------------------------
// gcq_in_if
// Pixel input channel: valid/ready with value, gain and frame start.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcq_in_if;
  logic                                valid;
  logic                                ready;
  logic        [gcq_pkg::PIX_W-1:0]    pixel_value;
  logic signed [gcq_pkg::GAIN_W-1:0]   gain_value;
  logic                                frame_start;

  modport source(output valid, pixel_value, gain_value, frame_start, input ready);
  modport sink(input valid, pixel_value, gain_value, frame_start, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gcq_out_if.sv
// ----------------------------------------------------------------------------
// gcq_out_if
// Result channel: valid/ready with the quantized pixel, flags and totals.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcq_out_if;
  logic                          valid;
  logic                          ready;
  logic [gcq_pkg::RES_W-1:0]     quantized;
  logic                          overflowed;
  logic                          bad_pixel;
  logic                          masked;
  logic [gcq_pkg::CNT_W-1:0]     overflow_total;
  logic [gcq_pkg::CNT_W-1:0]     bad_total;
  logic [gcq_pkg::CNT_W-1:0]     masked_total;
  logic [gcq_pkg::SUM_W-1:0]     deviation_total;

  modport source(output valid, quantized, overflowed, bad_pixel, masked, overflow_total,
                 bad_total, masked_total, deviation_total, input ready);
  modport sink(input valid, quantized, overflowed, bad_pixel, masked, overflow_total,
               bad_total, masked_total, deviation_total, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gain_correct_quantize_4bit_core.sv
// ----------------------------------------------------------------------------
// gain_correct_quantize_4bit_core
// Flat-field gain correction of one Q8.8 pixel by a Q4.12 gain, rounded
// and clamped to 4 bits, with per-frame overflow, bad, masked and deviation totals.
// ----------------------------------------------------------------------------
// A pixel whose quotient stays below 32.0 goes through these steps from
// acceptance to result: a range check on the quotient, the 13 quotient bits
// (one bit a cycle from the radix-2 restoring divider), the hand-back of the
// quotient, and a final step to round, flag and update the totals. A larger
// quotient, a zero gain included, makes the divider run over all 32
// numerator bits to get the low quotient bits. One pixel is in work at a
// time; the next one is accepted the cycle after the previous result enters
// the output register. The output register holds a result while the sink
// stalls, and a finished pixel waits behind it. The deviation threshold is
// written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module gain_correct_quantize_4bit_core #(
  parameter int PIXELS_MAX = gcq_pkg::PIXELS_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  gcq_in_if.sink                             pix,
  gcq_out_if.source                          res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gcq_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [gcq_pkg::DATA_W-1:0]    pwdata,
  output logic [gcq_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

  state_t                           state;
  logic [gcq_pkg::THR_W-1:0]        threshold;
  logic [gcq_pkg::PIX_W-1:0]        v_hold;
  logic                             pos_hold;
  logic                             zero_hold;
  logic                             fs_hold;

  logic [gcq_pkg::CNT_W-1:0]        overflow_count;
  logic [gcq_pkg::CNT_W-1:0]        bad_count;
  logic [gcq_pkg::CNT_W-1:0]        masked_count;
  logic [gcq_pkg::SUM_W-1:0]        deviation_sum;

  logic                             out_valid;
  logic [gcq_pkg::RES_W-1:0]        out_quantized;
  logic                             out_overflowed;
  logic                             out_bad;
  logic                             out_masked;

  logic                             accept;
  logic                             div_done;
  gcq_pkg::div_res_t                dres;
  logic [gcq_pkg::NUM_W-1:0]        numer;
  logic [gcq_pkg::DEN_W-1:0]        denom;
  logic [gcq_pkg::PIX_W+3:0]        v15;

  logic                             over;
  logic [gcq_pkg::Q_W:0]            rnd;
  logic [8:0]                       adr;
  logic [gcq_pkg::Q_W-1:0]          clamp_dev;
  logic [gcq_pkg::RES_W-1:0]        f_res;
  logic                             f_ovf;
  logic                             f_bad;
  logic                             nz;
  logic                             out_free;
  logic                             cfg_write;

  logic [gcq_pkg::CNT_W-1:0]        ovf_base;
  logic [gcq_pkg::CNT_W-1:0]        bad_base;
  logic [gcq_pkg::CNT_W-1:0]        msk_base;
  logic [gcq_pkg::SUM_W-1:0]        dev_base;
  logic [gcq_pkg::CNT_W-1:0]        overflow_count_next;
  logic [gcq_pkg::CNT_W-1:0]        bad_count_next;
  logic [gcq_pkg::CNT_W-1:0]        masked_count_next;
  logic [gcq_pkg::SUM_W-1:0]        deviation_sum_next;
  logic [gcq_pkg::SUM_W:0]          dev_wide;

  function automatic logic [gcq_pkg::CNT_W-1:0] sat_inc(
    input logic [gcq_pkg::CNT_W-1:0] c
  );
    return (c < gcq_pkg::CNT_W'(PIXELS_MAX)) ? c + 1'b1 : gcq_pkg::CNT_W'(PIXELS_MAX);
  endfunction

  assign accept    = pix.valid && pix.ready;
  assign pix.ready = (state == S_IDLE);
  assign out_free  = !out_valid || res.ready;

  // Numerator and divisor for the serial divider
  always_comb begin
    v15   = {pix.pixel_value, 4'b0} - {4'b0, pix.pixel_value};
    numer = pix.gain_value[gcq_pkg::GAIN_W-1]
          ? {v15, 12'b0}
          : {4'b0, pix.pixel_value, 12'b0};
    denom = pix.gain_value[gcq_pkg::GAIN_W-1]
          ? gcq_pkg::DEN_W'(~pix.gain_value + 16'sd1)
          : gcq_pkg::DEN_W'(pix.gain_value);
  end

  gcq_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .numer  (numer),
    .denom  (denom),
    .done   (div_done),
    .result (dres)
  );

  // Round, clamp, flag and work out the next totals
  always_comb begin
    over      = dres.sat || (dres.q >= gcq_pkg::OVER_LIMIT);
    rnd       = {1'b0, dres.q} + 14'd128;
    adr       = dres.q[7] ? 9'd256 - {1'b0, dres.q[7:0]} : {1'b0, dres.q[7:0]};
    clamp_dev = dres.q - gcq_pkg::CLAMP_BASE;
    nz        = (v_hold != '0);
    if (zero_hold) begin
      f_res = nz ? gcq_pkg::QMAX : '0;
      f_ovf = nz;
      f_bad = nz;
    end else begin
      f_res = over ? gcq_pkg::QMAX : rnd[11:8];
      f_ovf = over;
      if (!pos_hold && over)
        f_bad = dres.sat || (clamp_dev > gcq_pkg::Q_W'(threshold));
      else
        f_bad = adr > 9'(threshold);
    end

    ovf_base = fs_hold ? '0 : overflow_count;
    bad_base = fs_hold ? '0 : bad_count;
    msk_base = fs_hold ? '0 : masked_count;
    dev_base = fs_hold ? '0 : deviation_sum;

    overflow_count_next = f_ovf ? sat_inc(ovf_base) : ovf_base;
    bad_count_next      = f_bad ? sat_inc(bad_base) : bad_base;
    masked_count_next   = !pos_hold ? sat_inc(msk_base) : msk_base;
    dev_wide            = {1'b0, dev_base} + (pos_hold ? 33'(adr) : 33'd0);
    deviation_sum_next  = (dev_wide > gcq_pkg::DEV_SUM_MAX)
                        ? gcq_pkg::DEV_SUM_MAX[gcq_pkg::SUM_W-1:0]
                        : dev_wide[gcq_pkg::SUM_W-1:0];
  end

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == gcq_pkg::REG_THRESHOLD)
                   ? gcq_pkg::DATA_W'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      threshold      <= gcq_pkg::THR_RESET;
      overflow_count <= '0;
      bad_count      <= '0;
      masked_count   <= '0;
      deviation_sum  <= '0;
    end else begin
      if (cfg_write && paddr[2] == gcq_pkg::REG_THRESHOLD)
        threshold <= pwdata[gcq_pkg::THR_W-1:0];
      if (out_valid && res.ready && state != S_FIN)
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            v_hold    <= pix.pixel_value;
            pos_hold  <= !pix.gain_value[gcq_pkg::GAIN_W-1] && (pix.gain_value != '0);
            zero_hold <= (pix.gain_value == '0);
            fs_hold   <= pix.frame_start;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done)
            state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_quantized  <= f_res;
            out_overflowed <= f_ovf;
            out_bad        <= f_bad;
            out_masked     <= !pos_hold;
            overflow_count <= overflow_count_next;
            bad_count      <= bad_count_next;
            masked_count   <= masked_count_next;
            deviation_sum  <= deviation_sum_next;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid           = out_valid;
  assign res.quantized       = out_quantized;
  assign res.overflowed      = out_overflowed;
  assign res.bad_pixel       = out_bad;
  assign res.masked          = out_masked;
  assign res.overflow_total  = overflow_count;
  assign res.bad_total       = bad_count;
  assign res.masked_total    = masked_count;
  assign res.deviation_total = deviation_sum;

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside a division");

  a_ovf_clamps: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.overflowed |-> res.quantized == gcq_pkg::QMAX)
    else $error("overflowed beat not clamped");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.overflow_total <= gcq_pkg::CNT_W'(PIXELS_MAX)
               && res.masked_total <= gcq_pkg::CNT_W'(PIXELS_MAX))
    else $error("total above its cap");

  a_sum_cap: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> {1'b0, res.deviation_total} <= gcq_pkg::DEV_SUM_MAX)
    else $error("deviation total above its cap");

endmodule

`default_nettype wire

>>> hw/rtl/gcq_divider.sv
// ----------------------------------------------------------------------------
// gcq_divider
// Radix-2 restoring divider: one range check, then one quotient bit a cycle,
// 13 bits for an in-range quotient or a full-width pass for its low bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gcq_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [gcq_pkg::NUM_W-1:0]     numer,
  input  wire logic [gcq_pkg::DEN_W-1:0]     denom,
  output logic                               done,
  output gcq_pkg::div_res_t                  result
);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_STEP} dstate_t;

  dstate_t                        state;
  logic [gcq_pkg::NUM_W-1:0]      num;
  logic [gcq_pkg::DEN_W-1:0]      part;
  logic [gcq_pkg::DEN_W-1:0]      den;
  logic [4:0]                     cnt;

  logic [gcq_pkg::DEN_W:0]        trial;
  logic [gcq_pkg::DEN_W:0]        diff;
  logic                           fits;
  logic                           check_sat;

  always_comb begin
    trial     = {part, num[gcq_pkg::NUM_W-1]};
    fits      = trial >= {1'b0, den};
    diff      = trial - {1'b0, den};
    check_sat = num[gcq_pkg::NUM_W-1:gcq_pkg::Q_W] >= gcq_pkg::HI_W'(den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            num   <= numer;
            den   <= denom;
            state <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (check_sat) begin
            // quotient too wide: run all numerator bits, keep the low ones
            result.sat <= 1'b1;
            part       <= '0;
            cnt        <= 5'(gcq_pkg::NUM_W - 1);
            state      <= D_STEP;
          end else begin
            result.sat <= 1'b0;
            part       <= num[gcq_pkg::Q_W+gcq_pkg::DEN_W-1:gcq_pkg::Q_W];
            num        <= {num[gcq_pkg::Q_W-1:0], {gcq_pkg::HI_W{1'b0}}};
            cnt        <= 5'(gcq_pkg::Q_W - 1);
            state      <= D_STEP;
          end
        end
        D_STEP: begin
          part     <= gcq_pkg::DEN_W'(fits ? diff : trial);
          num      <= {num[gcq_pkg::NUM_W-2:0], 1'b0};
          result.q <= {result.q[gcq_pkg::Q_W-2:0], fits};
          if (cnt == 5'd0) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
